// ===== design/optd_pkg.sv =====
// Shared types and constants for the offset point track drive controller.
// Depends on nothing; used by the CORDIC, arithmetic and top level files.
package optd_pkg;

  localparam int TrigBits    = 30;
  localparam int CordicSteps = 30;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] TrigOne    = 34'sd1073741824;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    RegGainX   = 3'd0,
    RegGainY   = 3'd1,
    RegOffset  = 3'd2,
    RegInvOff  = 3'd3,
    RegRefSpd  = 3'd4,
    RegHalfTrk = 3'd5,
    RegMaxWhl  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [23:0] gain_x;
    logic [23:0] gain_y;
    logic [19:0] point_offset;
    logic [23:0] inverse_offset;
    logic [19:0] reference_speed;
    logic [19:0] half_track;
    logic [19:0] max_wheel_speed;
  } cfg_t;

  // Arc tangent of 2^-i as a fraction of a turn, 2^32 per turn.
  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] r;
    r = 34'sd0;
    case (i)
      0:  r = 34'sh20000000;  1:  r = 34'sh12E4051E;  2:  r = 34'sh09FB385B;
      3:  r = 34'sh051111D4;  4:  r = 34'sh028B0D43;  5:  r = 34'sh0145D7E1;
      6:  r = 34'sh00A2F61E;  7:  r = 34'sh00517C55;  8:  r = 34'sh0028BE53;
      9:  r = 34'sh00145F2F;  10: r = 34'sh000A2F98;  11: r = 34'sh000517CC;
      12: r = 34'sh00028BE6;  13: r = 34'sh000145F3;  14: r = 34'sh0000A2FA;
      15: r = 34'sh0000517D;  16: r = 34'sh000028BE;  17: r = 34'sh0000145F;
      18: r = 34'sh00000A30;  19: r = 34'sh00000518;  20: r = 34'sh0000028C;
      21: r = 34'sh00000146;  22: r = 34'sh000000A3;  23: r = 34'sh00000051;
      24: r = 34'sh00000029;  25: r = 34'sh00000014;  26: r = 34'sh0000000A;
      27: r = 34'sh00000005;  28: r = 34'sh00000003;  29: r = 34'sh00000001;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [31:0] r;
    if (v > 80'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -80'sh80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/optd_cordic.sv =====
// Pipelined CORDIC: cosine and sine in Q2.30 of a binary angle, one stage per step.
// Depends on optd_pkg; a load stage, the rotation stages and an output register, with side payload carried along.
module optd_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int SIDE_W     = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [ANGLE_BITS-1:0]    angle_a_i,
  input  logic [ANGLE_BITS-1:0]    angle_b_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic signed [33:0]       cos_a_o,
  output logic signed [33:0]       sin_a_o,
  output logic signed [33:0]       cos_b_o,
  output logic signed [33:0]       sin_b_o,
  output logic [SIDE_W-1:0]        side_o
);
  localparam int N = optd_pkg::CordicSteps;

  logic               v_q   [N+1];
  logic signed [33:0] xa_q  [N+1];
  logic signed [33:0] ya_q  [N+1];
  logic signed [33:0] za_q  [N+1];
  logic signed [33:0] xb_q  [N+1];
  logic signed [33:0] yb_q  [N+1];
  logic signed [33:0] zb_q  [N+1];
  logic               fa_q  [N+1];
  logic               fb_q  [N+1];
  logic [SIDE_W-1:0]  sd_q  [N+1];

  // Fold an angle into the right half plane; flag a half-turn flip.
  function automatic logic [34:0] fold(input logic [ANGLE_BITS-1:0] a);
    logic signed [33:0] z;
    logic               f;
    z = 34'(signed'({a, {(32 - ANGLE_BITS){1'b0}}}));
    f = 1'b0;
    if (z > 34'sh40000000) begin
      z = z - 34'sh80000000; f = 1'b1;
    end else if (z < -34'sh40000000) begin
      z = z + 34'sh80000000; f = 1'b1;
    end
    return {f, z};
  endfunction

  // Load stage.
  always_ff @(posedge clk_i) begin
    logic [34:0] fa, fb;
    fa = fold(angle_a_i);
    fb = fold(angle_b_i);
    xa_q[0] <= optd_pkg::CordicGain; ya_q[0] <= '0; za_q[0] <= fa[33:0]; fa_q[0] <= fa[34];
    xb_q[0] <= optd_pkg::CordicGain; yb_q[0] <= '0; zb_q[0] <= fb[33:0]; fb_q[0] <= fb[34];
    sd_q[0] <= side_i;
  end

  // One rotation step per stage.
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (!za_q[i][33]) begin
        xa_q[i+1] <= xa_q[i] - (ya_q[i] >>> i);
        ya_q[i+1] <= ya_q[i] + (xa_q[i] >>> i);
        za_q[i+1] <= za_q[i] - optd_pkg::atan_turn(i);
      end else begin
        xa_q[i+1] <= xa_q[i] + (ya_q[i] >>> i);
        ya_q[i+1] <= ya_q[i] - (xa_q[i] >>> i);
        za_q[i+1] <= za_q[i] + optd_pkg::atan_turn(i);
      end
      if (!zb_q[i][33]) begin
        xb_q[i+1] <= xb_q[i] - (yb_q[i] >>> i);
        yb_q[i+1] <= yb_q[i] + (xb_q[i] >>> i);
        zb_q[i+1] <= zb_q[i] - optd_pkg::atan_turn(i);
      end else begin
        xb_q[i+1] <= xb_q[i] + (yb_q[i] >>> i);
        yb_q[i+1] <= yb_q[i] - (xb_q[i] >>> i);
        zb_q[i+1] <= zb_q[i] + optd_pkg::atan_turn(i);
      end
      fa_q[i+1] <= fa_q[i];
      fb_q[i+1] <= fb_q[i];
      sd_q[i+1] <= sd_q[i];
    end
  end

  // Advance valid bits.
  for (genvar i = 0; i <= N; i++) begin : g_valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i] <= 1'b0;
      else if (i == 0) v_q[i] <= valid_i;
      else v_q[i] <= v_q[(i == 0) ? 0 : i-1];
    end
  end

  function automatic logic signed [33:0] clamp(input logic signed [33:0] v, input logic f);
    logic signed [33:0] r;
    r = v;
    if (r > optd_pkg::TrigOne) r = optd_pkg::TrigOne;
    if (r < -optd_pkg::TrigOne) r = -optd_pkg::TrigOne;
    return f ? -r : r;
  endfunction

  // Clamp, unfold and register the result.
  always_ff @(posedge clk_i) begin
    cos_a_o <= clamp(xa_q[N], fa_q[N]);
    sin_a_o <= clamp(ya_q[N], fa_q[N]);
    cos_b_o <= clamp(xb_q[N], fb_q[N]);
    sin_b_o <= clamp(yb_q[N], fb_q[N]);
    side_o  <= sd_q[N];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= v_q[N];
  end
endmodule

// ===== design/optd_law.sv =====
// Control law pipeline: offset point, errors, velocity vector, speed, turn, tracks.
// Depends on optd_pkg; takes trig values from optd_cordic.
module optd_law #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  optd_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  input  logic                stop_i,
  input  logic signed [31:0]  tx_i,
  input  logic signed [31:0]  ty_i,
  input  logic signed [31:0]  rx_i,
  input  logic signed [31:0]  ry_i,
  input  logic signed [33:0]  cr_i,
  input  logic signed [33:0]  sr_i,
  input  logic signed [33:0]  ct_i,
  input  logic signed [33:0]  st_i,
  output logic                valid_o,
  output logic signed [31:0]  fwd_o,
  output logic signed [31:0]  turn_o,
  output logic signed [20:0]  left_o,
  output logic signed [20:0]  right_o,
  output logic signed [31:0]  ex_o,
  output logic signed [31:0]  ey_o
);
  localparam int T = optd_pkg::TrigBits;
  localparam int F = FRACTION_BITS;
  localparam int L = 10;

  function automatic logic signed [79:0] rsh(input logic signed [79:0] v, input int s);
    return (v + (80'sd1 <<< (s - 1))) >>> s;
  endfunction

  logic       v_q [L];
  logic       st_q [L-1];
  logic signed [33:0] cr_q [4];
  logic signed [33:0] sr_q [4];

  // Stage 1: offset products and feed forward products.
  logic signed [79:0] pox_q, poy_q, ffx_q, ffy_q;
  logic signed [31:0] tx1_q, ty1_q, rx1_q, ry1_q;
  always_ff @(posedge clk_i) begin
    pox_q <= 80'(signed'({1'b0, cfg_i.point_offset})) * 80'(cr_i);
    poy_q <= 80'(signed'({1'b0, cfg_i.point_offset})) * 80'(sr_i);
    ffx_q <= 80'(signed'({1'b0, cfg_i.reference_speed})) * 80'(ct_i);
    ffy_q <= 80'(signed'({1'b0, cfg_i.reference_speed})) * 80'(st_i);
    tx1_q <= tx_i; ty1_q <= ty_i; rx1_q <= rx_i; ry1_q <= ry_i;
  end

  // Stage 2: offset point and error.
  logic signed [31:0] ex2_q, ey2_q;
  logic signed [79:0] ffx2_q, ffy2_q;
  always_ff @(posedge clk_i) begin
    logic signed [31:0] bx, by;
    bx = optd_pkg::sat32(80'(rx1_q) + rsh(pox_q, T));
    by = optd_pkg::sat32(80'(ry1_q) + rsh(poy_q, T));
    ex2_q  <= optd_pkg::sat32(80'(tx1_q) - 80'(bx));
    ey2_q  <= optd_pkg::sat32(80'(ty1_q) - 80'(by));
    ffx2_q <= rsh(ffx_q, T);
    ffy2_q <= rsh(ffy_q, T);
  end

  // Stage 3: gain products.
  logic signed [79:0] gx3_q, gy3_q, ffx3_q, ffy3_q;
  logic signed [31:0] ex3_q, ey3_q;
  always_ff @(posedge clk_i) begin
    gx3_q  <= 80'(signed'({1'b0, cfg_i.gain_x})) * 80'(ex2_q);
    gy3_q  <= 80'(signed'({1'b0, cfg_i.gain_y})) * 80'(ey2_q);
    ffx3_q <= ffx2_q; ffy3_q <= ffy2_q;
    ex3_q  <= ex2_q; ey3_q <= ey2_q;
  end

  // Stage 4: velocity vector.
  logic signed [31:0] u1_q, u2_q, ex4_q, ey4_q;
  always_ff @(posedge clk_i) begin
    u1_q  <= optd_pkg::sat32(ffx3_q + rsh(gx3_q, F));
    u2_q  <= optd_pkg::sat32(ffy3_q + rsh(gy3_q, F));
    ex4_q <= ex3_q; ey4_q <= ey3_q;
  end

  // Stage 5: rotate into the body frame (four products, then sums).
  logic signed [79:0] a5_q, b5_q, c5_q, d5_q;
  logic signed [31:0] ex5_q, ey5_q;
  always_ff @(posedge clk_i) begin
    a5_q <= 80'(cr_q[3]) * 80'(u1_q);
    b5_q <= 80'(sr_q[3]) * 80'(u2_q);
    c5_q <= 80'(cr_q[3]) * 80'(u2_q);
    d5_q <= 80'(sr_q[3]) * 80'(u1_q);
    ex5_q <= ex4_q; ey5_q <= ey4_q;
  end

  // Stage 6: forward speed and lateral term.
  logic signed [31:0] fwd6_q, lat6_q, ex6_q, ey6_q;
  always_ff @(posedge clk_i) begin
    fwd6_q <= optd_pkg::sat32(rsh(a5_q + b5_q, T));
    lat6_q <= optd_pkg::sat32(rsh(c5_q - d5_q, T));
    ex6_q  <= ex5_q; ey6_q <= ey5_q;
  end

  // Stage 7: turn product.
  logic signed [79:0] turn7_q;
  logic signed [31:0] fwd7_q, ex7_q, ey7_q;
  always_ff @(posedge clk_i) begin
    turn7_q <= 80'(signed'({1'b0, cfg_i.inverse_offset})) * 80'(lat6_q);
    fwd7_q  <= fwd6_q;
    ex7_q   <= ex6_q; ey7_q <= ey6_q;
  end

  // Stage 8: turn rate.
  logic signed [31:0] turn8_q, fwd8_q, ex8_q, ey8_q;
  always_ff @(posedge clk_i) begin
    turn8_q <= optd_pkg::sat32(rsh(turn7_q, F));
    fwd8_q  <= fwd7_q;
    ex8_q   <= ex7_q; ey8_q <= ey7_q;
  end

  // Stage 9: half track product.
  logic signed [79:0] ht9_q;
  logic signed [31:0] turn9_q, fwd9_q, ex9_q, ey9_q;
  always_ff @(posedge clk_i) begin
    ht9_q   <= 80'(signed'({1'b0, cfg_i.half_track})) * 80'(turn8_q);
    turn9_q <= turn8_q;
    fwd9_q  <= fwd8_q;
    ex9_q   <= ex8_q; ey9_q <= ey8_q;
  end

  // Stage 10: track speeds and clip; stop zeroes the word.
  always_ff @(posedge clk_i) begin
    logic signed [79:0] ht, lft, rgt, lim;
    ht   = rsh(ht9_q, F);
    lft  = 80'(fwd9_q) - ht;
    rgt  = 80'(fwd9_q) + ht;
    lim  = 80'(signed'({1'b0, cfg_i.max_wheel_speed}));
    if (lft > lim) lft = lim;
    if (lft < -lim) lft = -lim;
    if (rgt > lim) rgt = lim;
    if (rgt < -lim) rgt = -lim;
    if (st_q[L-2]) begin
      fwd_o <= '0; turn_o <= '0; left_o <= '0; right_o <= '0; ex_o <= '0; ey_o <= '0;
    end else begin
      fwd_o <= fwd9_q; turn_o <= turn9_q; left_o <= lft[20:0]; right_o <= rgt[20:0];
      ex_o <= ex9_q; ey_o <= ey9_q;
    end
  end

  // Carry trig and stop flags alongside.
  always_ff @(posedge clk_i) begin
    cr_q[0] <= cr_i; sr_q[0] <= sr_i; st_q[0] <= stop_i;
    for (int i = 1; i < 4; i++) begin
      cr_q[i] <= cr_q[i-1]; sr_q[i] <= sr_q[i-1];
    end
    for (int i = 1; i < L-1; i++) st_q[i] <= st_q[i-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < L; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < L; i++) v_q[i] <= v_q[i-1];
    end
  end
  assign valid_o = v_q[L-1];
endmodule

// ===== design/offset_point_track_drive_controller_core.sv =====
// Top level of the offset point track drive controller.
// Depends on optd_pkg, optd_cordic and optd_law.
//
// Usage: drive start high with a pose word; it is taken on any rising edge,
// since busy stays low: one word per cycle is sustained. The result word
// appears after passing through the CORDIC pipeline and then the control law
// pipeline, marked by done_o for one cycle with all six result fields.
// The sink cannot stall; every result must be taken when done_o is high.
// Configuration: write cfg_we_i with cfg_idx_i and cfg_data_i; unknown indexes
// are dropped. Write only while no word is in flight.
// Reset clears valid bits and loads register defaults; nothing is in flight.
// A stop action gives a result word of all zero fields through the same pipelines.
module offset_point_track_drive_controller_core #(
  parameter int FRACTION_BITS = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic               action_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [15:0] target_heading_i,
  input  logic signed [31:0] robot_x_i,
  input  logic signed [31:0] robot_y_i,
  input  logic signed [15:0] robot_heading_i,
  output logic               done_o,
  output logic signed [31:0] forward_speed_o,
  output logic signed [31:0] turn_rate_o,
  output logic signed [20:0] left_track_speed_o,
  output logic signed [20:0] right_track_speed_o,
  output logic signed [31:0] error_x_o,
  output logic signed [31:0] error_y_o
);
  localparam int SideW = 1 + 4 * 32;

  optd_pkg::cfg_t cfg_q;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_x          <= 24'd19661;
      cfg_q.gain_y          <= 24'd19661;
      cfg_q.point_offset    <= 20'd13107;
      cfg_q.inverse_offset  <= 24'd327680;
      cfg_q.reference_speed <= 20'd9830;
      cfg_q.half_track      <= 20'd11600;
      cfg_q.max_wheel_speed <= 20'd42598;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        optd_pkg::RegGainX:   cfg_q.gain_x          <= cfg_data_i;
        optd_pkg::RegGainY:   cfg_q.gain_y          <= cfg_data_i;
        optd_pkg::RegOffset:  cfg_q.point_offset    <= cfg_data_i[19:0];
        optd_pkg::RegInvOff:  cfg_q.inverse_offset  <= cfg_data_i;
        optd_pkg::RegRefSpd:  cfg_q.reference_speed <= cfg_data_i[19:0];
        optd_pkg::RegHalfTrk: cfg_q.half_track      <= cfg_data_i[19:0];
        optd_pkg::RegMaxWhl:  cfg_q.max_wheel_speed <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic             tv;
  logic [SideW-1:0] side;
  logic signed [33:0] cr, sr, ct, st;

  optd_cordic #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(SideW)) u_cordic (
    .clk_i, .rst_ni,
    .valid_i   (start),
    .angle_a_i (ANGLE_BITS'($unsigned(robot_heading_i))),
    .angle_b_i (ANGLE_BITS'($unsigned(target_heading_i))),
    .side_i    ({action_i, target_x_i, target_y_i, robot_x_i, robot_y_i}),
    .valid_o   (tv),
    .cos_a_o   (cr), .sin_a_o (sr), .cos_b_o (ct), .sin_b_o (st),
    .side_o    (side)
  );

  optd_law #(.FRACTION_BITS(FRACTION_BITS)) u_law (
    .clk_i, .rst_ni,
    .cfg_i   (cfg_q),
    .valid_i (tv),
    .stop_i  (side[128]),
    .tx_i    (side[127:96]),
    .ty_i    (side[95:64]),
    .rx_i    (side[63:32]),
    .ry_i    (side[31:0]),
    .cr_i    (cr), .sr_i (sr), .ct_i (ct), .st_i (st),
    .valid_o (done_o),
    .fwd_o   (forward_speed_o),
    .turn_o  (turn_rate_o),
    .left_o  (left_track_speed_o),
    .right_o (right_track_speed_o),
    .ex_o    (error_x_o),
    .ey_o    (error_y_o)
  );
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for offset_point_track_drive_controller_core.
// Depends on optd_pkg and the RTL; predicts each result word from its own
// fixed-point model of the tracking law and checks it against done_o output.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int Latency = 42;
  localparam int TrigFrac = 30;
  localparam int Frac = 16;
  localparam longint TrigUnit = 64'sd1 << TrigFrac;

  typedef struct {
    logic act;
    logic signed [31:0] tx, ty, rx, ry;
    logic [15:0] th, rh;
  } pose_t;

  typedef struct {
    logic signed [31:0] fwd, turn;
    logic signed [20:0] left, right;
    logic signed [31:0] ex, ey;
  } drive_cmd_t;

  // Arc tangent of 2^-i in 2^32 per turn.
  localparam longint ArcTab [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic action_i = 1'b0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, robot_x_i = '0, robot_y_i = '0;
  logic signed [15:0] target_heading_i = '0, robot_heading_i = '0;
  logic done_o;
  logic signed [31:0] forward_speed_o, turn_rate_o, error_x_o, error_y_o;
  logic signed [20:0] left_track_speed_o, right_track_speed_o;

  optd_pkg::cfg_t cfg;
  drive_cmd_t pending_cmds[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  bit allow_gaps = 1'b1;

  always #4 clk_i = ~clk_i;

  offset_point_track_drive_controller_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .action_i, .target_x_i, .target_y_i, .target_heading_i,
    .robot_x_i, .robot_y_i, .robot_heading_i, .done_o,
    .forward_speed_o, .turn_rate_o, .left_track_speed_o, .right_track_speed_o,
    .error_x_o, .error_y_o
  );

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // CORDIC cosine and sine of a binary angle, Q2.30.
  task automatic heading_trig(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'($signed({ang, 16'h0000}));
    x = 64'sd652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1'b1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ArcTab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ArcTab[i];
      end
      x = nx;
    end
    x = clamp_mag(x, TrigUnit);
    y = clamp_mag(y, TrigUnit);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Compute the drive command word for one pose word.
  task automatic predict_drive(input pose_t p, output drive_cmd_t r);
    longint cr, sr, ct, st, bx, by, ex, ey, u1, u2, fwd, lat, turn, dt, lt, rt;
    r = '{default: '0};
    if (p.act) return;
    heading_trig(p.rh, cr, sr);
    heading_trig(p.th, ct, st);
    bx = sat_word(longint'(p.rx) + rnd_shift(longint'(cfg.point_offset) * cr, TrigFrac));
    by = sat_word(longint'(p.ry) + rnd_shift(longint'(cfg.point_offset) * sr, TrigFrac));
    ex = sat_word(longint'(p.tx) - bx);
    ey = sat_word(longint'(p.ty) - by);
    u1 = sat_word(rnd_shift(longint'(cfg.reference_speed) * ct, TrigFrac)
                  + rnd_shift(longint'(cfg.gain_x) * ex, Frac));
    u2 = sat_word(rnd_shift(longint'(cfg.reference_speed) * st, TrigFrac)
                  + rnd_shift(longint'(cfg.gain_y) * ey, Frac));
    fwd = sat_word(rnd_shift(cr * u1 + sr * u2, TrigFrac));
    lat = sat_word(rnd_shift(cr * u2 - sr * u1, TrigFrac));
    turn = sat_word(rnd_shift(longint'(cfg.inverse_offset) * lat, Frac));
    dt = rnd_shift(longint'(cfg.half_track) * turn, Frac);
    lt = clamp_mag(fwd - dt, longint'(cfg.max_wheel_speed));
    rt = clamp_mag(fwd + dt, longint'(cfg.max_wheel_speed));
    r.fwd = fwd[31:0];
    r.turn = turn[31:0];
    r.left = lt[20:0];
    r.right = rt[20:0];
    r.ex = ex[31:0];
    r.ey = ey[31:0];
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    errors++;
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, field, got, want);
  endtask

  // Compare every strobed result word with the oldest prediction.
  always @(posedge clk_i) begin
    drive_cmd_t w;
    if (rst_ni && done_o) begin
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("ERROR %0t: result word with nothing expected", $realtime);
      end else begin
        w = pending_cmds.pop_front();
        words_checked++;
        if (forward_speed_o !== w.fwd) report_mismatch("forward_speed", forward_speed_o, w.fwd);
        if (turn_rate_o !== w.turn) report_mismatch("turn_rate", turn_rate_o, w.turn);
        if (left_track_speed_o !== w.left)
          report_mismatch("left_track_speed", left_track_speed_o, w.left);
        if (right_track_speed_o !== w.right)
          report_mismatch("right_track_speed", right_track_speed_o, w.right);
        if (error_x_o !== w.ex) report_mismatch("error_x", error_x_o, w.ex);
        if (error_y_o !== w.ey) report_mismatch("error_y", error_y_o, w.ey);
      end
    end
  end

  // Hold the word on the ports until taken, then queue its prediction.
  task automatic send_pose(input pose_t p);
    drive_cmd_t r;
    start <= 1'b1;
    action_i <= p.act;
    target_x_i <= p.tx;
    target_y_i <= p.ty;
    target_heading_i <= p.th;
    robot_x_i <= p.rx;
    robot_y_i <= p.ry;
    robot_heading_i <= p.rh;
    do @(posedge clk_i); while (busy);
    predict_drive(p, r);
    pending_cmds.insert(pending_cmds.size(), r);
    words_sent++;
    if (allow_gaps && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Drop start and let the pipeline empty before touching registers.
  task automatic drain_pipe();
    start <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (Latency + 6) @(posedge clk_i);
  endtask

  // Hold the enable high across a run of writes; the caller drops it.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      optd_pkg::RegGainX:   cfg.gain_x = data;
      optd_pkg::RegGainY:   cfg.gain_y = data;
      optd_pkg::RegOffset:  cfg.point_offset = data[19:0];
      optd_pkg::RegInvOff:  cfg.inverse_offset = data;
      optd_pkg::RegRefSpd:  cfg.reference_speed = data[19:0];
      optd_pkg::RegHalfTrk: cfg.half_track = data[19:0];
      optd_pkg::RegMaxWhl:  cfg.max_wheel_speed = data[19:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [23:0] gx, gy, po, io, rs, ht, mw);
    write_reg(optd_pkg::RegGainX, gx);
    write_reg(optd_pkg::RegGainY, gy);
    write_reg(optd_pkg::RegOffset, po);
    write_reg(optd_pkg::RegInvOff, io);
    write_reg(optd_pkg::RegRefSpd, rs);
    write_reg(optd_pkg::RegHalfTrk, ht);
    write_reg(optd_pkg::RegMaxWhl, mw);
    write_reg(RegUnused, 24'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  function automatic pose_t make_pose(input logic act, input longint tx, ty, rx, ry,
                                      input logic [15:0] th, rh);
    pose_t p;
    p.act = act;
    p.tx = tx[31:0];
    p.ty = ty[31:0];
    p.rx = rx[31:0];
    p.ry = ry[31:0];
    p.th = th;
    p.rh = rh;
    return p;
  endfunction

  // Mostly near-target poses so the law stays unsaturated; some full-range ones.
  function automatic pose_t rand_pose();
    pose_t p;
    p.act = ($urandom_range(99) < 10);
    p.th = 16'($urandom());
    p.rh = 16'($urandom());
    p.tx = $urandom();
    p.ty = $urandom();
    if ($urandom_range(2) == 0) begin
      p.rx = $urandom();
      p.ry = $urandom();
    end else begin
      p.tx = $signed(p.tx) >>> $urandom_range(4, 16);
      p.ty = $signed(p.ty) >>> $urandom_range(4, 16);
      p.rx = p.tx + $signed(32'($urandom_range(0, 1 << 19)) - 32'sd262144);
      p.ry = p.ty + $signed(32'($urandom_range(0, 1 << 19)) - 32'sd262144);
    end
    return p;
  endfunction

  task automatic test_default_regs();
    send_pose(make_pose(1'b0, 0, 0, 0, 0, 16'h0000, 16'h0000));
    send_pose(make_pose(1'b0, 65536, 0, 0, 0, 16'h4000, 16'h0000));
    send_pose(make_pose(1'b0, 0, 65536, 0, 0, 16'h8000, 16'hC000));
    send_pose(make_pose(1'b0, 0, 0, 0, 0, 16'h7FFF, 16'h8000));
    send_pose(make_pose(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -64'sd2147483648,
                        -64'sd2147483648, 16'h2000, 16'hE000));
    send_pose(make_pose(1'b0, -64'sd2147483648, -64'sd2147483648, 32'sh7FFFFFFF,
                        32'sh7FFFFFFF, 16'hFFFF, 16'h0001));
    send_pose(make_pose(1'b0, 32'sh7FFFFFFF, 0, 32'sh7FFFFFF0, 0, 16'h0000, 16'h0000));
    send_pose(make_pose(1'b0, 131072, -131072, 0, 0, 16'h6000, 16'h9000));
  endtask

  task automatic test_stop_action();
    send_pose(make_pose(1'b1, 65536, 65536, 0, 0, 16'h1234, 16'h4321));
    send_pose(make_pose(1'b1, 32'sh7FFFFFFF, -64'sd2147483648, 0, 0, 16'hFFFF, 16'h8000));
    send_pose(make_pose(1'b0, 65536, 65536, 0, 0, 16'h1234, 16'h4321));
  endtask

  // Extreme registers: largest values, then all registers zero, then an offset that disagrees with its reciprocal.
  task automatic test_register_extremes();
    drain_pipe();
    load_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFF, 24'hFFFFFF, 24'hFFFFF, 24'hFFFFF, 24'hFFFFF);
    send_pose(make_pose(1'b0, 65536, -65536, 0, 0, 16'h1000, 16'h3000));
    send_pose(make_pose(1'b0, 100, 0, 0, 0, 16'h0000, 16'h0000));
    send_pose(make_pose(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -64'sd2147483648, 0,
                        16'h8000, 16'h4000));
    drain_pipe();
    load_regs(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
    send_pose(make_pose(1'b0, 65536, 65536, 0, 0, 16'h1000, 16'h3000));
    send_pose(make_pose(1'b0, -65536, 300000, 7, -9, 16'hC000, 16'h7000));
    drain_pipe();
    // Offset and its reciprocal deliberately disagree.
    load_regs(24'd19661, 24'd19661, 24'd65536, 24'd1000, 24'd9830, 24'd11600, 24'd42598);
    send_pose(make_pose(1'b0, 65536, 65536, 0, 0, 16'h2000, 16'h5000));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      drain_pipe();
      if (ph == 0)
        load_regs(24'd19661, 24'd19661, 24'd13107, 24'd327680, 24'd9830, 24'd11600, 24'd42598);
      else
        load_regs(24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12)),
                  24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12)),
                  24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                  24'($urandom()));
      // Back-to-back words for one whole phase.
      allow_gaps = (ph != 2);
      for (int n = 0; n < 135; n++) send_pose(rand_pose());
    end
    allow_gaps = 1'b1;
    drain_pipe();
  endtask

  initial begin
    cfg = '{gain_x: 24'd19661, gain_y: 24'd19661, point_offset: 20'd13107,
            inverse_offset: 24'd327680, reference_speed: 20'd9830,
            half_track: 20'd11600, max_wheel_speed: 20'd42598};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_regs();
    test_stop_action();
    test_register_extremes();
    test_random_traffic();
    $display("Sent %0d pose words over 10 register settings, checked %0d command words.",
             words_sent, words_checked);
    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d words outstanding", errors, pending_cmds.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d words outstanding", pending_cmds.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/optd_pkg.sv
design/optd_cordic.sv
design/optd_law.sv
design/offset_point_track_drive_controller_core.sv
sim/testbench.sv
